/* design/esc_dtc_pkg.sv */
// ----------------------------------------------------------------------------
// ESC duty and threshold conditioner package
// Shared types and constants: request/result payloads, register indexes and
// fixed scaling constants of the duty and zero-cross threshold path.
// ----------------------------------------------------------------------------
package esc_dtc_pkg;

   localparam int DUTY_W   = 17;
   localparam int ADC_W    = 12;
   localparam int THR_W    = 16;
   localparam int PERIOD_W = 16;
   localparam int GAIN_W   = 8;
   localparam int CSR_IDX_W = 3;

   // bus voltage times duty, before the threshold shift
   localparam int PROD_W = ADC_W + DUTY_W;
   localparam int THRESHOLD_SHIFT = 18;
   localparam logic [PERIOD_W-1:0] SPEED_HOLD_PERIOD = 16'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_DUTY         = 3'd0,
      CSR_MAX_DUTY         = 3'd1,
      CSR_PRESYNC_DUTY_CAP = 3'd2,
      CSR_SLEW_UP_RATE     = 3'd3,
      CSR_SLEW_DOWN_RATE   = 3'd4,
      CSR_SAG_ENTER_LEVEL  = 3'd5,
      CSR_SAG_EXIT_LEVEL   = 3'd6,
      CSR_SAG_GAIN         = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [ADC_W-1:0]    throttle_sample;
      logic [ADC_W-1:0]    bus_voltage_sample;
      logic                loop_closed;
      logic                zc_synced;
      logic [PERIOD_W-1:0] step_period;
      logic [DUTY_W-1:0]   external_duty;
   } req_payload_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_out;
      logic [THR_W-1:0]  zc_threshold;
      logic              sag_limiting;
   } rsp_payload_type;

endpackage

/* design/esc_duty_and_threshold_conditioner.sv */
// ----------------------------------------------------------------------------
// ESC duty and threshold conditioner
// Per PWM sample: zero-cross threshold smoothing, throttle to duty mapping,
// slew limiting, top-speed hold and bus-sag duty reduction with hysteresis.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one request per PWM-rate sample (valid/ready). Carries throttle
//            and bus readings, closed-loop and sync flags, step period and the
//            startup duty.
//   rsp_*  : one result per request, in order: duty, threshold, sag flag.
//   csr_*  : register writes (enable, index, data); they are to be only
//            written while no request is in flight (user's duty, not enforced).
// A request passes the input register, then the conditioning logic into the
// result register, which also updates the duty, slew, threshold, bus filter
// and sag state.
// Throughput is one request per cycle while the receiver does not stall; the
// state feedback closes within the conditioning logic, so back-to-back
// requests see each other's state.
// When the receiver stalls, the result holds and the input register fills;
// req_ready then drops until rsp_ready returns.
// Reset clears all state to zero (open loop) and loads the register defaults.
// ----------------------------------------------------------------------------
module esc_duty_and_threshold_conditioner
   import esc_dtc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DUTY_W-1:0]     csr_wdata
);

   // registers
   logic [DUTY_W-1:0] min_duty_ff, max_duty_ff, presync_cap_ff;
   logic [DUTY_W-1:0] slew_up_ff, slew_down_ff;
   logic [ADC_W-1:0]  sag_enter_ff, sag_exit_ff;
   logic [GAIN_W-1:0] sag_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_duty_ff    <= 17'd2000;
         max_duty_ff    <= 17'd120000;
         presync_cap_ff <= 17'd40000;
         slew_up_ff     <= 17'd64;
         slew_down_ff   <= 17'd256;
         sag_enter_ff   <= 12'd2000;
         sag_exit_ff    <= 12'd2100;
         sag_gain_ff    <= 8'd16;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_DUTY:         min_duty_ff    <= csr_wdata;
            CSR_MAX_DUTY:         max_duty_ff    <= csr_wdata;
            CSR_PRESYNC_DUTY_CAP: presync_cap_ff <= csr_wdata;
            CSR_SLEW_UP_RATE:     slew_up_ff     <= csr_wdata;
            CSR_SLEW_DOWN_RATE:   slew_down_ff   <= csr_wdata;
            CSR_SAG_ENTER_LEVEL:  sag_enter_ff   <= csr_wdata[ADC_W-1:0];
            CSR_SAG_EXIT_LEVEL:   sag_exit_ff    <= csr_wdata[ADC_W-1:0];
            CSR_SAG_GAIN:         sag_gain_ff    <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic            in_valid_ff;
   req_payload_type in_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;
   logic            advance;
   logic            step;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_payload;
      end
   end

   // state
   logic [DUTY_W-1:0] duty_now_ff, slew_mem_ff;
   logic [THR_W-1:0]  thr_smooth_ff;
   logic [ADC_W-1:0]  bus_filt_ff;
   logic              sag_active_ff, was_cl_ff;

   logic [DUTY_W-1:0] duty_now_in, slew_mem_in;
   logic [THR_W-1:0]  thr_smooth_in;
   logic [ADC_W-1:0]  bus_filt_in;
   logic              sag_active_in, was_cl_in;
   rsp_payload_type   rsp_in;

   // conditioning logic
   logic              cl, entry;
   logic [DUTY_W-1:0] prev_duty;
   logic [PROD_W-1:0] vbus_prod, vbus_shift;
   logic [THR_W-1:0]  raw_thr;
   logic [THR_W:0]    up_gap;
   logic [THR_W:0]    dn_gap;
   logic [THR_W-1:0]  up_step;
   logic [THR_W-1:0]  dn_step;
   logic [THR_W-1:0]  thr_cl;
   logic [DUTY_W-1:0] cap, span;
   logic [PROD_W-1:0] thr_prod;
   logic [DUTY_W:0]   d_map, d_slew, d_hold, d_sag, d_fin;
   logic [DUTY_W-1:0] sm_base;
   logic [DUTY_W:0]   sm_ext;
   logic [ADC_W-1:0]  bf_base;
   logic [ADC_W+3:0]  bf_sum;
   logic [ADC_W-1:0]  bf_new;
   logic              sag_base, sag_new;
   logic [ADC_W-1:0]  sag_depth;
   logic [ADC_W+GAIN_W-1:0] cut_prod;
   logic [ADC_W+GAIN_W-5:0] cut;

   always_comb begin
      cl        = in_ff.loop_closed;
      entry     = cl && !was_cl_ff;
      prev_duty = (cl && was_cl_ff) ? duty_now_ff : in_ff.external_duty;

      // raw threshold, saturated
      vbus_prod  = PROD_W'(in_ff.bus_voltage_sample) * PROD_W'(prev_duty);
      vbus_shift = vbus_prod >> THRESHOLD_SHIFT;
      raw_thr    = (vbus_shift > PROD_W'(17'h0FFFF)) ? 16'hFFFF : vbus_shift[THR_W-1:0];

      // smoothing: fast attack (1/8), slow decay (1/256, at least one)
      up_gap  = {1'b0, raw_thr} - {1'b0, thr_smooth_ff} + 17'd4;
      up_step = THR_W'(up_gap[THR_W:3]);
      dn_gap  = {1'b0, thr_smooth_ff} - {1'b0, raw_thr} + 17'd128;
      dn_step = THR_W'(dn_gap[THR_W:8]);
      if (dn_step == '0) dn_step = 16'd1;
      if (entry)
         thr_cl = raw_thr;
      else if (raw_thr >= thr_smooth_ff)
         thr_cl = thr_smooth_ff + up_step;
      else
         thr_cl = thr_smooth_ff - dn_step;

      // throttle onto [min, cap]
      cap      = in_ff.zc_synced ? max_duty_ff : presync_cap_ff;
      span     = (cap > min_duty_ff) ? cap - min_duty_ff : '0;
      thr_prod = PROD_W'(in_ff.throttle_sample) * PROD_W'(span);
      d_map    = {1'b0, min_duty_ff} + {1'b0, thr_prod[PROD_W-1:ADC_W]};
      if (d_map > {1'b0, cap}) d_map = {1'b0, cap};

      // slew limit against the previous command
      sm_base = entry ? in_ff.external_duty : slew_mem_ff;
      sm_ext  = {1'b0, sm_base};
      d_slew  = d_map;
      if (d_map > sm_ext) begin
         if (d_map - sm_ext > {1'b0, slew_up_ff}) d_slew = sm_ext + {1'b0, slew_up_ff};
      end else if (d_map < sm_ext) begin
         if (sm_ext - d_map > {1'b0, slew_down_ff}) d_slew = sm_ext - {1'b0, slew_down_ff};
      end

      // no increase at top speed
      d_hold = d_slew;
      if (in_ff.step_period <= SPEED_HOLD_PERIOD && d_slew > {1'b0, prev_duty})
         d_hold = {1'b0, prev_duty};

      // bus filter (7/8 old + 1/8 new), seeded on loop entry
      bf_base = entry ? in_ff.bus_voltage_sample : bus_filt_ff;
      bf_sum  = ({4'd0, bf_base} << 3) - {4'd0, bf_base}
                + {4'd0, in_ff.bus_voltage_sample};
      bf_new  = bf_sum[ADC_W+2:3];

      // sag hysteresis and cut
      sag_base = entry ? 1'b0 : sag_active_ff;
      sag_new  = sag_base;
      if (!sag_base && bf_new < sag_enter_ff)
         sag_new = 1'b1;
      else if (sag_base && bf_new > sag_exit_ff)
         sag_new = 1'b0;
      sag_depth = (bf_new < sag_enter_ff) ? sag_enter_ff - bf_new : '0;
      cut_prod  = (ADC_W+GAIN_W)'(sag_depth) * (ADC_W+GAIN_W)'(sag_gain_ff);
      cut       = cut_prod[ADC_W+GAIN_W-1:4];
      d_sag     = d_hold;
      if (sag_new) begin
         if ((DUTY_W+1)'(cut) >= d_hold) d_sag = {1'b0, min_duty_ff};
         else                            d_sag = d_hold - (DUTY_W+1)'(cut);
      end
      d_fin = (d_sag < {1'b0, min_duty_ff}) ? {1'b0, min_duty_ff} : d_sag;

      if (cl) begin
         thr_smooth_in = thr_cl;
         slew_mem_in   = d_slew[DUTY_W-1:0];
         bus_filt_in   = bf_new;
         sag_active_in = sag_new;
         duty_now_in   = d_fin[DUTY_W-1:0];
         was_cl_in     = 1'b1;
      end else begin
         thr_smooth_in = raw_thr;
         slew_mem_in   = slew_mem_ff;
         bus_filt_in   = bus_filt_ff;
         sag_active_in = 1'b0;
         duty_now_in   = in_ff.external_duty;
         was_cl_in     = 1'b0;
      end

      rsp_in.duty_out     = duty_now_in;
      rsp_in.zc_threshold = thr_smooth_in;
      rsp_in.sag_limiting = sag_active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_now_ff   <= '0;
         slew_mem_ff   <= '0;
         thr_smooth_ff <= '0;
         bus_filt_ff   <= '0;
         sag_active_ff <= 1'b0;
         was_cl_ff     <= 1'b0;
      end else if (step) begin
         duty_now_ff   <= duty_now_in;
         slew_mem_ff   <= slew_mem_in;
         thr_smooth_ff <= thr_smooth_in;
         bus_filt_ff   <= bus_filt_in;
         sag_active_ff <= sag_active_in;
         was_cl_ff     <= was_cl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   a_duty_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.duty_out == duty_now_ff)
      else $error("result duty differs from held duty");

   a_thr_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.zc_threshold == thr_smooth_ff)
      else $error("result threshold differs from smoother");

   a_no_sag_open_loop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !was_cl_ff) |-> !rsp_ff.sag_limiting)
      else $error("sag flag set outside closed loop");

   a_request_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> in_valid_ff)
      else $error("accepted request lost from input register");

   a_step_gives_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("processed request produced no result");

endmodule
